FILE: rtl/core/ppvl_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ppvl_pkg
// Shared types and constants for the pure-pursuit velocity limiter core.
// ----------------------------------------------------------------------------
package ppvl_pkg;

    // shared iterative unit
    localparam int IterW     = 48;   // remainder / radicand accumulator
    localparam int DenW      = 32;   // divisor
    localparam int ResW      = 18;   // quotient or root
    localparam int SqBitW    = 36;   // root bit weight
    localparam int CntW      = 5;
    localparam int DivSteps  = 16;
    localparam int SqrtSteps = 18;
    localparam int DivShift  = DivSteps - 1;
    localparam logic [SqBitW-1:0] SqBitInit = SqBitW'(1) << (2 * (SqrtSteps - 1));

    typedef enum logic {
        OP_DIV,
        OP_SQRT
    } t_iter_op;

    typedef struct packed {
        logic     start;
        t_iter_op op;
    } t_iter_req;

    typedef enum logic [2:0] {
        CFG_FORWARD_SPEED,
        CFG_VERTICAL_SPEED,
        CFG_TURN_RATE,
        CFG_FORWARD_ACCEL,
        CFG_VERTICAL_ACCEL,
        CFG_TURN_ACCEL,
        CFG_STOP_THRESHOLD,
        CFG_TICK_PERIOD
    } t_cfg_idx;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_DSQ_X,
        ST_DSQ_Y,
        ST_THR,
        ST_MUL_Z,
        ST_SQZ_GO,
        ST_SQZ_WAIT,
        ST_SQD_GO,
        ST_SQD_WAIT,
        ST_MUL_F,
        ST_SQF_GO,
        ST_SQF_WAIT,
        ST_MUL_L,
        ST_MUL_R,
        ST_CMP,
        ST_DIV_GO,
        ST_DIV_WAIT,
        ST_RAW,
        ST_STEP_F,
        ST_LIM_F,
        ST_STEP_Z,
        ST_LIM_Z,
        ST_STEP_Y,
        ST_LIM_Y,
        ST_DONE
    } t_state;

endpackage
`default_nettype wire

FILE: rtl/core/ppvl_iter.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ppvl_iter
// Shared bit-serial unit: restoring divide or integer square root, one
// compare-and-subtract per cycle.
// ----------------------------------------------------------------------------
module ppvl_iter import ppvl_pkg::*; (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire t_iter_req       i_req,
    input  wire logic [IterW-1:0] i_num,
    input  wire logic [DenW-1:0]  i_den,
    output logic                 o_busy,
    output logic [ResW-1:0]      o_res
);

    logic              r_busy;
    logic [CntW-1:0]   r_cnt;
    t_iter_op          r_op;
    logic [IterW-1:0]  r_acc;
    logic [IterW-1:0]  r_b;
    logic [SqBitW-1:0] r_bit;
    logic [ResW-1:0]   r_q;

    logic [IterW-1:0]  w_cmp;
    logic [IterW-1:0]  w_diff;
    logic              w_ge;

    assign w_cmp  = (r_op == OP_SQRT) ? r_b + IterW'(r_bit) : r_b;
    assign w_ge   = r_acc >= w_cmp;
    assign w_diff = r_acc - w_cmp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_req.start) begin
            r_busy <= 1'b1;
            r_cnt  <= (i_req.op == OP_SQRT) ? CntW'(SqrtSteps - 1) : CntW'(DivSteps - 1);
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == '0) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_op  <= i_req.op;
            r_acc <= i_num;
            r_b   <= (i_req.op == OP_SQRT) ? '0 : IterW'(i_den) << DivShift;
            r_bit <= SqBitInit;
            r_q   <= '0;
        end else if (r_busy) begin
            if (w_ge) begin
                r_acc <= w_diff;
            end
            if (r_op == OP_SQRT) begin
                r_b   <= w_ge ? (r_b >> 1) + IterW'(r_bit) : r_b >> 1;
                r_bit <= r_bit >> 2;
            end else begin
                r_b <= r_b >> 1;
                r_q <= {r_q[ResW-2:0], w_ge};
            end
        end
    end

    assign o_busy = r_busy;
    assign o_res  = (r_op == OP_SQRT) ? r_b[ResW-1:0] : r_q;

endmodule
`default_nettype wire

FILE: rtl/core/pure_pursuit_velocity_limiter_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pure_pursuit_velocity_limiter_core
// 3D pure-pursuit velocity command with deceleration caps and per-axis
// acceleration limiting against the previous command.
// ----------------------------------------------------------------------------
//
//  channel  | direction | handshake                   | payload
//  ---------+-----------+-----------------------------+---------------------------
//  goal in  | in        | i_in_valid / o_in_stall     | i_goal_x/y/z, i_goal_valid
//  command  | out       | o_out_valid / i_out_stall   | o_cmd_forward/vertical/yaw
//  config   | in        | i_cfg_we (no wait)          | i_cfg_index, i_cfg_data
//
//  Each transaction passes through the shared divide / square-root unit before
//  the next can be accepted: three square roots of 18 steps and one division
//  of 16 steps, plus multiply and limit states.
//  o_in_stall is high whenever the sequencer is not idle.
//  A finished command waits in the output register; a new transaction may be
//  accepted meanwhile, and its last state holds until that command is taken.
//  Synchronous active-low reset restores register defaults and zero history.
// ----------------------------------------------------------------------------
module pure_pursuit_velocity_limiter_core import ppvl_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic signed [15:0] i_goal_x,
    input  wire logic signed [15:0] i_goal_y,
    input  wire logic signed [15:0] i_goal_z,
    input  wire logic        i_goal_valid,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic signed [15:0] o_cmd_forward,
    output logic signed [15:0] o_cmd_vertical,
    output logic signed [15:0] o_cmd_yaw,
    input  wire logic        i_cfg_we,
    input  wire logic [2:0]  i_cfg_index,
    input  wire logic [15:0] i_cfg_data
);

    // Clamp v to last +/- step, then saturate to 16 bits.
    function automatic logic signed [15:0] f_limit(
        input logic signed [15:0] v,
        input logic signed [15:0] last,
        input logic [14:0]        step
    );
        logic signed [18:0] d;
        logic signed [18:0] s;
        logic signed [18:0] t;
        d = 19'(v) - 19'(last);
        s = signed'({4'b0, step});
        if (d > s) begin
            t = 19'(last) + s;
        end else if (d < -s) begin
            t = 19'(last) - s;
        end else begin
            t = 19'(v);
        end
        if (t > 19'sd32767) begin
            f_limit = 16'sh7fff;
        end else if (t < -19'sd32768) begin
            f_limit = 16'sh8000;
        end else begin
            f_limit = t[15:0];
        end
    endfunction

    // configuration
    logic [14:0] r_fs, r_vs, r_tr, r_fa, r_va, r_ta, r_thr;
    logic [15:0] r_tp;

    // control
    t_state r_state, n_state;
    logic   r_out_valid;
    logic signed [15:0] r_last_f, r_last_z, r_last_y;

    // captured goal
    logic [15:0] r_ax, r_ay, r_az;
    logic        r_gx_pos, r_gy_pos, r_gz_pos, r_gv;

    // working values
    logic [31:0] r_dsq;
    logic [29:0] r_thrsq;
    logic [35:0] r_num;
    logic [17:0] r_capz, r_capf;
    logic [15:0] r_dxy, r_q;
    logic [41:0] r_lhs;
    logic [46:0] r_rhs;
    logic        r_br;
    logic [14:0] r_step;
    logic signed [15:0] r_vf, r_vz, r_vy;
    logic signed [15:0] r_cmd_f, r_cmd_z, r_cmd_y;

    // shared unit
    t_iter_req        w_req;
    logic [IterW-1:0] w_num;
    logic [DenW-1:0]  w_den;
    logic             w_busy;
    logic [ResW-1:0]  w_res;

    logic w_accept, w_emit;

    // raw command
    logic        w_mov_z, w_mov_p;
    logic [14:0] w_mz, w_f0, w_f, w_y;
    logic signed [15:0] w_vf, w_vz, w_vy;

    ppvl_iter u_iter (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .i_num   (w_num),
        .i_den   (w_den),
        .o_busy  (w_busy),
        .o_res   (w_res)
    );

    assign w_accept = i_in_valid && !o_in_stall;
    // release the command only once the output register is free
    assign w_emit   = (r_state == ST_DONE) && (!r_out_valid || !i_out_stall);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:     if (i_in_valid) n_state = ST_DSQ_X;
            ST_DSQ_X:    n_state = ST_DSQ_Y;
            ST_DSQ_Y:    n_state = ST_THR;
            ST_THR:      n_state = ST_MUL_Z;
            ST_MUL_Z:    n_state = ST_SQZ_GO;
            ST_SQZ_GO:   n_state = ST_SQZ_WAIT;
            ST_SQZ_WAIT: if (!w_busy) n_state = ST_SQD_GO;
            ST_SQD_GO:   n_state = ST_SQD_WAIT;
            ST_SQD_WAIT: if (!w_busy) n_state = ST_MUL_F;
            ST_MUL_F:    n_state = ST_SQF_GO;
            ST_SQF_GO:   n_state = ST_SQF_WAIT;
            ST_SQF_WAIT: if (!w_busy) n_state = ST_MUL_L;
            ST_MUL_L:    n_state = ST_MUL_R;
            ST_MUL_R:    n_state = ST_CMP;
            ST_CMP:      n_state = ST_DIV_GO;
            ST_DIV_GO:   n_state = ST_DIV_WAIT;
            ST_DIV_WAIT: if (!w_busy) n_state = ST_RAW;
            ST_RAW:      n_state = ST_STEP_F;
            ST_STEP_F:   n_state = ST_LIM_F;
            ST_LIM_F:    n_state = ST_STEP_Z;
            ST_STEP_Z:   n_state = ST_LIM_Z;
            ST_LIM_Z:    n_state = ST_STEP_Y;
            ST_STEP_Y:   n_state = ST_LIM_Y;
            ST_LIM_Y:    n_state = ST_DONE;
            ST_DONE:     if (w_emit) n_state = ST_IDLE;
            default:     n_state = ST_IDLE;
        endcase
    end

    // sequencer outputs: stall and shared-unit request
    always_comb begin
        o_in_stall = (r_state != ST_IDLE);
        w_req      = '{start: 1'b0, op: OP_SQRT};
        w_num      = IterW'(r_num);
        w_den      = r_dsq;
        unique case (r_state)
            ST_SQZ_GO, ST_SQF_GO: begin
                w_req.start = 1'b1;
            end
            ST_SQD_GO: begin
                w_req.start = 1'b1;
                w_num       = IterW'(r_dsq);
            end
            ST_DIV_GO: begin
                w_req = '{start: 1'b1, op: OP_DIV};
                // lhs / dsq when the yaw cap is not reached, else rhs / (2048*|y|)
                w_num = r_br ? IterW'(r_lhs) : IterW'(r_rhs);
                w_den = r_br ? r_dsq : DenW'(r_ay) << 11;
            end
            default: begin
            end
        endcase
    end

    // raw command before limiting
    always_comb begin
        w_mov_z = r_gv && (r_az > 16'(r_thr));
        w_mov_p = r_gv && (r_dsq > 32'(r_thrsq));
        w_mz    = (18'(r_vs) < r_capz) ? r_vs : r_capz[14:0];
        w_f0    = r_br ? r_fs : r_q[14:0];
        w_f     = (18'(w_f0) > r_capf) ? r_capf[14:0] : w_f0;
        w_y     = r_br ? r_q[14:0] : r_tr;
        w_vz    = '0;
        w_vf    = '0;
        w_vy    = '0;
        if (w_mov_z) begin
            w_vz = r_gz_pos ? signed'({1'b0, w_mz}) : -signed'({1'b0, w_mz});
        end
        if (w_mov_p) begin
            if (r_gx_pos) begin
                w_vf = signed'({1'b0, w_f});
                w_vy = r_gy_pos ? signed'({1'b0, w_y}) : -signed'({1'b0, w_y});
            end else begin
                // goal not ahead: turn in place
                w_vy = r_gy_pos ? signed'({1'b0, r_tr}) : -signed'({1'b0, r_tr});
            end
        end
    end

    // control registers, configuration and command history
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
            r_last_f    <= '0;
            r_last_z    <= '0;
            r_last_y    <= '0;
            r_fs        <= 15'd1638;
            r_vs        <= 15'd819;
            r_tr        <= 15'd1638;
            r_fa        <= 15'd1638;
            r_va        <= 15'd819;
            r_ta        <= 15'd1638;
            r_thr       <= 15'd102;
            r_tp        <= 16'd3277;
        end else begin
            r_state <= n_state;
            if (w_emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                ST_LIM_F: r_last_f <= f_limit(r_vf, r_last_f, r_step);
                ST_LIM_Z: r_last_z <= f_limit(r_vz, r_last_z, r_step);
                ST_LIM_Y: r_last_y <= f_limit(r_vy, r_last_y, r_step);
                default: begin
                end
            endcase
            if (i_cfg_we) begin
                unique case (t_cfg_idx'(i_cfg_index))
                    CFG_FORWARD_SPEED:  r_fs  <= i_cfg_data[14:0];
                    CFG_VERTICAL_SPEED: r_vs  <= i_cfg_data[14:0];
                    CFG_TURN_RATE:      r_tr  <= i_cfg_data[14:0];
                    CFG_FORWARD_ACCEL:  r_fa  <= i_cfg_data[14:0];
                    CFG_VERTICAL_ACCEL: r_va  <= i_cfg_data[14:0];
                    CFG_TURN_ACCEL:     r_ta  <= i_cfg_data[14:0];
                    CFG_STOP_THRESHOLD: r_thr <= i_cfg_data[14:0];
                    CFG_TICK_PERIOD:    r_tp  <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
        end
    end

    // datapath registers, one multiply per state
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_ax     <= i_goal_x[15] ? 16'(-i_goal_x) : i_goal_x;
            r_ay     <= i_goal_y[15] ? 16'(-i_goal_y) : i_goal_y;
            r_az     <= i_goal_z[15] ? 16'(-i_goal_z) : i_goal_z;
            r_gx_pos <= !i_goal_x[15] && (i_goal_x != '0);
            r_gy_pos <= !i_goal_y[15] && (i_goal_y != '0);
            r_gz_pos <= !i_goal_z[15] && (i_goal_z != '0);
            r_gv     <= i_goal_valid;
        end
        if (w_emit) begin
            r_cmd_f <= r_last_f;
            r_cmd_z <= r_last_z;
            r_cmd_y <= r_last_y;
        end
        unique case (r_state)
            ST_DSQ_X:    r_dsq   <= 32'(r_ax) * 32'(r_ax);
            ST_DSQ_Y:    r_dsq   <= r_dsq + 32'(r_ay) * 32'(r_ay);
            ST_THR:      r_thrsq <= 30'(r_thr) * 30'(r_thr);
            ST_MUL_Z:    r_num   <= (36'(r_az) * 36'(r_va)) << 3;
            ST_SQZ_WAIT: r_capz  <= w_res;
            ST_SQD_WAIT: r_dxy   <= w_res[15:0];
            ST_MUL_F:    r_num   <= (36'(r_dxy) * 36'(r_fa)) << 3;
            ST_SQF_WAIT: r_capf  <= w_res;
            ST_MUL_L:    r_lhs   <= (42'(r_ay) * 42'(r_fs)) << 11;
            ST_MUL_R:    r_rhs   <= 47'(r_tr) * 47'(r_dsq);
            ST_CMP:      r_br    <= 47'(r_lhs) <= r_rhs;
            ST_DIV_WAIT: r_q     <= w_res[15:0];
            ST_RAW: begin
                r_vf <= w_vf;
                r_vz <= w_vz;
                r_vy <= w_vy;
            end
            ST_STEP_F:   r_step  <= 15'((31'(r_fa) * 31'(r_tp)) >> 16);
            ST_STEP_Z:   r_step  <= 15'((31'(r_va) * 31'(r_tp)) >> 16);
            ST_STEP_Y:   r_step  <= 15'((31'(r_ta) * 31'(r_tp)) >> 16);
            default: begin
            end
        endcase
    end

    assign o_out_valid    = r_out_valid;
    assign o_cmd_forward  = r_cmd_f;
    assign o_cmd_vertical = r_cmd_z;
    assign o_cmd_yaw      = r_cmd_y;

endmodule
`default_nettype wire
